@@ rtl/vn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vn_pkg
// Shared constants for the 3-D vector normalize pipeline.
// ---------------------------------------------------------------------------
package vn_pkg;

  // fixed widths of the result and configuration fields
  localparam int OUT_W = 24;
  localparam int CFG_W = 24;

  // defaults for the top level parameters
  localparam int DEF_IN_WIDTH  = 24;
  localparam int DEF_FRAC_BITS = 22;

endpackage
`default_nettype wire

@@ rtl/vn_sqrt_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vn_sqrt_pipe
// Pipelined integer square root, one root bit resolved per register stage.
// ---------------------------------------------------------------------------
module vn_sqrt_pipe #(
  parameter int IN_WIDTH = vn_pkg::DEF_IN_WIDTH,
  parameter int SIDE_W   = 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    vld_i,
  input  wire logic [2*IN_WIDTH+1:0]   sum_i,
  input  wire logic [SIDE_W-1:0]       side_i,
  output logic                         vld_o,
  output logic [IN_WIDTH:0]            root_o,
  output logic [SIDE_W-1:0]            side_o
);

  localparam int ROOT_W = IN_WIDTH + 1;
  localparam int SUM_W  = 2 * ROOT_W;
  localparam int RW     = ROOT_W + 2;

  logic [RW-1:0]     rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SUM_W-1:0]  s_r    [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];
  logic              vld_r  [ROOT_W];

  logic [RW-1:0]     rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];
  logic [SUM_W-1:0]  s_nxt    [ROOT_W];
  logic [SIDE_W-1:0] side_nxt [ROOT_W];
  logic              vld_nxt  [ROOT_W];

  // one restoring step per stage: bring down two radicand bits, try 4*root+1
  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [RW-1:0]     rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RW-1:0]     rem_sh;
    logic [RW-1:0]     trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in      = '0;
      assign root_in     = '0;
      assign s_nxt[k]    = sum_i;
      assign side_nxt[k] = side_i;
      assign vld_nxt[k]  = vld_i;
    end else begin : g_next
      assign rem_in      = rem_r[k-1];
      assign root_in     = root_r[k-1];
      assign s_nxt[k]    = s_r[k-1];
      assign side_nxt[k] = side_r[k-1];
      assign vld_nxt[k]  = vld_r[k-1];
    end

    assign rem_sh      = {rem_in[RW-3:0], s_nxt[k][SUM_W-1-2*k -: 2]};
    assign trial       = {root_in, 2'b01};
    assign ge          = (rem_sh >= trial);
    assign rem_nxt[k]  = ge ? (rem_sh - trial) : rem_sh;
    assign root_nxt[k] = {root_in[ROOT_W-2:0], ge};
  end

  // stage registers, valid bits cleared by reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < ROOT_W; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_nxt[k];
      end
      if (en) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        s_r[k]    <= s_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign vld_o  = vld_r[ROOT_W-1];
  assign root_o = root_r[ROOT_W-1];
  assign side_o = side_r[ROOT_W-1];

endmodule
`default_nettype wire

@@ rtl/vn_div_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vn_div_pipe
// Pipelined restoring divider, (mag << FRAC_BITS) / den, one quotient bit
// per register stage. Assumes mag <= den, so the quotient fits FRAC_BITS+1.
// ---------------------------------------------------------------------------
module vn_div_pipe #(
  parameter int IN_WIDTH  = vn_pkg::DEF_IN_WIDTH,
  parameter int FRAC_BITS = vn_pkg::DEF_FRAC_BITS,
  parameter int SIDE_W    = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  vld_i,
  input  wire logic [IN_WIDTH-1:0]   mag_i,
  input  wire logic [IN_WIDTH:0]     den_i,
  input  wire logic [SIDE_W-1:0]     side_i,
  output logic                       vld_o,
  output logic [FRAC_BITS:0]         quot_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int ROOT_W = IN_WIDTH + 1;
  localparam int QW     = FRAC_BITS + 1;
  localparam int RMW    = ROOT_W + 1;

  logic [RMW-1:0]    rem_r  [QW];
  logic [QW-1:0]     q_r    [QW];
  logic [ROOT_W-1:0] den_r  [QW];
  logic [SIDE_W-1:0] side_r [QW];
  logic              vld_r  [QW];

  logic [RMW-1:0]    rem_nxt  [QW];
  logic [QW-1:0]     q_nxt    [QW];
  logic [ROOT_W-1:0] den_nxt  [QW];
  logic [SIDE_W-1:0] side_nxt [QW];
  logic              vld_nxt  [QW];

  // the partial remainder starts at mag >> 1; mag[0] is the only nonzero
  // dividend bit brought down, the fraction bits below it are zero
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RMW-1:0] rem_in;
    logic [QW-1:0]  q_in;
    logic           dbit;
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] den_x;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in      = RMW'(mag_i >> 1);
      assign q_in        = '0;
      assign dbit        = mag_i[0];
      assign den_nxt[k]  = den_i;
      assign side_nxt[k] = side_i;
      assign vld_nxt[k]  = vld_i;
    end else begin : g_next
      assign rem_in      = rem_r[k-1];
      assign q_in        = q_r[k-1];
      assign dbit        = 1'b0;
      assign den_nxt[k]  = den_r[k-1];
      assign side_nxt[k] = side_r[k-1];
      assign vld_nxt[k]  = vld_r[k-1];
    end

    assign rem_sh     = {rem_in[RMW-2:0], dbit};
    assign den_x      = {1'b0, den_nxt[k]};
    assign ge         = (rem_sh >= den_x);
    assign rem_nxt[k] = ge ? (rem_sh - den_x) : rem_sh;
    assign q_nxt[k]   = {q_in[QW-2:0], ge};
  end

  // stage registers, valid bits cleared by reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_nxt[k];
      end
      if (en) begin
        rem_r[k]  <= rem_nxt[k];
        q_r[k]    <= q_nxt[k];
        den_r[k]  <= den_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign vld_o  = vld_r[QW-1];
  assign quot_o = q_r[QW-1];
  assign side_o = side_r[QW-1];

endmodule
`default_nettype wire

@@ rtl/vector3_normalize_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vector3_normalize_unit
// Scales a signed 3-D vector to unit length, results in signed Q1.FRAC_BITS.
//
//   channel | ports                              | transfer
//   --------+------------------------------------+-------------------------
//   input   | comp_x, comp_y, comp_z             | in_valid & in_ready
//   result  | unit_x, unit_y, unit_z, too_small  | out_valid & out_ready
//   config  | cfg_wr_data (min_norm)             | cfg_wr_en, no wait
//
// One vector per cycle sustained unless a held result stalls the pipeline.
// Stages in order: magnitude, square, sum, one stage per root bit
// of the square root, threshold compare, one stage per quotient bit of the
// three parallel dividers, and the output register.
// Synchronous active-low reset clears the valid bits and min_norm.
// A stalled result freezes the whole pipeline; in_ready follows that stall.
// ---------------------------------------------------------------------------
module vector3_normalize_unit #(
  parameter int IN_WIDTH  = vn_pkg::DEF_IN_WIDTH,
  parameter int FRAC_BITS = vn_pkg::DEF_FRAC_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [IN_WIDTH-1:0]      comp_x,
  input  wire logic signed [IN_WIDTH-1:0]      comp_y,
  input  wire logic signed [IN_WIDTH-1:0]      comp_z,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [vn_pkg::OUT_W-1:0]      unit_x,
  output logic signed [vn_pkg::OUT_W-1:0]      unit_y,
  output logic signed [vn_pkg::OUT_W-1:0]      unit_z,
  output logic                                 too_small,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [vn_pkg::CFG_W-1:0]        cfg_wr_data
);

  localparam int OUT_W  = vn_pkg::OUT_W;
  localparam int CFG_W  = vn_pkg::CFG_W;
  localparam int ROOT_W = IN_WIDTH + 1;
  localparam int SUM_W  = 2 * ROOT_W;
  localparam int SQ_W   = 2 * IN_WIDTH;
  localparam int QW     = FRAC_BITS + 1;
  localparam int CW     = (ROOT_W > CFG_W) ? ROOT_W : CFG_W;
  localparam int EW     = ((QW > OUT_W) ? QW : OUT_W) + 1;
  localparam int SIDE_W = 3 + 3 * IN_WIDTH;

  logic en;

  logic [CFG_W-1:0] min_norm_r;

  logic [2:0][IN_WIDTH-1:0] mag0_r, mag1_r, mag2_r;
  logic [2:0]               neg0_r, neg1_r, neg2_r;
  logic [2:0][SQ_W-1:0]     sq1_r;
  logic [SUM_W-1:0]         sum2_r;
  logic                     v0_r, v1_r, v2_r;

  logic                     sq_vld;
  logic [ROOT_W-1:0]        sq_root;
  logic [SIDE_W-1:0]        sq_side;

  logic                     v3_r;
  logic                     small3_r;
  logic [ROOT_W-1:0]        norm3_r;
  logic [2:0][IN_WIDTH-1:0] mag3_r;
  logic [2:0]               neg3_r;

  logic                     dv_vld;
  logic [2:0]               dv_side0;
  logic [2:0][QW-1:0]       dv_q;
  logic                     dv_neg1, dv_neg2;

  logic                     out_valid_r;
  logic [2:0][OUT_W-1:0]    unit_r;
  logic                     too_small_r;

  // saturating signed encode of a quotient magnitude
  function automatic logic [OUT_W-1:0] encode_unit(input logic [QW-1:0] q, input logic neg);
    logic [EW-1:0] qe;
    logic [EW-1:0] lim;
    qe = EW'(q);
    if (neg) begin
      lim = EW'(1) << (OUT_W - 1);
      if (qe > lim) qe = lim;
      return OUT_W'(-qe[OUT_W-1:0]);
    end else begin
      lim = (EW'(1) << (OUT_W - 1)) - EW'(1);
      if (qe > lim) qe = lim;
      return qe[OUT_W-1:0];
    end
  endfunction

  // whole pipeline advances unless a finished result is held
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_norm_r <= '0;
    end else if (cfg_wr_en) begin
      min_norm_r <= cfg_wr_data;
    end
  end

  // front end valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= sq_vld;
    end
  end

  // magnitudes, squares, sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r    <= {comp_z[IN_WIDTH-1], comp_y[IN_WIDTH-1], comp_x[IN_WIDTH-1]};
      mag0_r[0] <= comp_x[IN_WIDTH-1] ? (~comp_x + 1'b1) : comp_x;
      mag0_r[1] <= comp_y[IN_WIDTH-1] ? (~comp_y + 1'b1) : comp_y;
      mag0_r[2] <= comp_z[IN_WIDTH-1] ? (~comp_z + 1'b1) : comp_z;

      mag1_r <= mag0_r;
      neg1_r <= neg0_r;
      for (int i = 0; i < 3; i++) begin
        sq1_r[i] <= SQ_W'(mag0_r[i]) * SQ_W'(mag0_r[i]);
      end

      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
      sum2_r <= SUM_W'(sq1_r[0]) + SUM_W'(sq1_r[1]) + SUM_W'(sq1_r[2]);
    end
  end

  vn_sqrt_pipe #(
    .IN_WIDTH (IN_WIDTH),
    .SIDE_W   (SIDE_W)
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v2_r),
    .sum_i  (sum2_r),
    .side_i ({neg2_r, mag2_r}),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // threshold compare on the norm
  always_ff @(posedge clk) begin
    if (en) begin
      norm3_r  <= sq_root;
      small3_r <= (CW'(sq_root) <= CW'(min_norm_r));
      {neg3_r, mag3_r} <= sq_side;
    end
  end

  // three dividers in lockstep; lane 0 carries valid and the flag
  vn_div_pipe #(
    .IN_WIDTH  (IN_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (3)
  ) u_div_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v3_r),
    .mag_i  (mag3_r[0]),
    .den_i  (norm3_r),
    .side_i ({small3_r, neg3_r[0], 1'b0}),
    .vld_o  (dv_vld),
    .quot_o (dv_q[0]),
    .side_o (dv_side0)
  );

  vn_div_pipe #(
    .IN_WIDTH  (IN_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (1)
  ) u_div_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v3_r),
    .mag_i  (mag3_r[1]),
    .den_i  (norm3_r),
    .side_i (neg3_r[1]),
    .vld_o  (),
    .quot_o (dv_q[1]),
    .side_o (dv_neg1)
  );

  vn_div_pipe #(
    .IN_WIDTH  (IN_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (1)
  ) u_div_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v3_r),
    .mag_i  (mag3_r[2]),
    .den_i  (norm3_r),
    .side_i (neg3_r[2]),
    .vld_o  (),
    .quot_o (dv_q[2]),
    .side_o (dv_neg2)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      too_small_r <= dv_side0[2] | dv_side0[0];
      if (dv_side0[2]) begin
        unit_r <= '0;
      end else begin
        unit_r[0] <= encode_unit(dv_q[0], dv_side0[1]);
        unit_r[1] <= encode_unit(dv_q[1], dv_neg1);
        unit_r[2] <= encode_unit(dv_q[2], dv_neg2);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign unit_x    = unit_r[0];
  assign unit_y    = unit_r[1];
  assign unit_z    = unit_r[2];
  assign too_small = too_small_r;

endmodule
`default_nettype wire

@@ tb/tb_vector3_normalize_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_vector3_normalize_unit
// Drives signed 3-D vectors through the normalize pipeline and checks every
// unit vector and too_small flag against an integer predictor, across
// several min_norm thresholds, with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module tb_vector3_normalize_unit;

  localparam int IW        = vn_pkg::DEF_IN_WIDTH;
  localparam int FB        = vn_pkg::DEF_FRAC_BITS;
  localparam int OUT_W     = vn_pkg::OUT_W;
  localparam int CFG_W     = vn_pkg::CFG_W;
  localparam int LATENCY   = IW + FB + 7;
  localparam int WD_LIMIT  = 20000;

  typedef struct packed {
    logic signed [IW-1:0] x;
    logic signed [IW-1:0] y;
    logic signed [IW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] ux;
    logic signed [OUT_W-1:0] uy;
    logic signed [OUT_W-1:0] uz;
    logic                    small_f;
  } unit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IW-1:0] comp_x = '0, comp_y = '0, comp_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] unit_x, unit_y, unit_z;
  logic too_small;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  vector3_normalize_unit #(.IN_WIDTH(IW), .FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z), .too_small(too_small),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vec_t  pending_vecs[$];
  unit_t expected_units[$];
  logic [CFG_W-1:0] min_norm_cfg = '0;
  int errors = 0;
  int matched = 0;
  int n_small = 0;
  int sent = 0;
  int idle_cycles = 0;
  int stall_hold = 0;
  bit hold_sender = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  // integer square root, bit by bit
  function automatic logic [63:0] root_of(logic [63:0] s);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [OUT_W-1:0] scale_comp(logic signed [IW-1:0] c,
                                                         logic [63:0] norm);
    logic [63:0] mag, q;
    logic neg;
    neg = c[IW-1];
    mag = neg ? 64'(-$signed(65'(c))) : 64'(c);
    mag = mag & ((64'd1 << IW) - 1);
    q = (mag << FB) / norm;
    if (neg) begin
      if (q > (64'd1 << (OUT_W-1))) q = 64'd1 << (OUT_W-1);
      return -$signed(q[OUT_W-1:0]);
    end
    if (q > (64'd1 << (OUT_W-1)) - 1) q = (64'd1 << (OUT_W-1)) - 1;
    return q[OUT_W-1:0];
  endfunction

  function automatic unit_t normalize_vec(vec_t v);
    unit_t r;
    logic [63:0] sum, norm;
    longint sx, sy, sz;
    sx = longint'(v.x);
    sy = longint'(v.y);
    sz = longint'(v.z);
    sum = 64'(sx * sx + sy * sy + sz * sz);
    norm = root_of(sum);
    if (norm <= 64'(min_norm_cfg)) begin
      r = '0;
      r.small_f = 1'b1;
    end else begin
      r.ux = scale_comp(v.x, norm);
      r.uy = scale_comp(v.y, norm);
      r.uz = scale_comp(v.z, norm);
      r.small_f = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  // driver: presents queued vectors with random gaps
  always @(posedge clk) begin
    int gap;
    if (in_valid && in_ready) begin
      expected_units.push_back(normalize_vec({comp_x, comp_y, comp_z}));
      void'(pending_vecs.pop_front());
      sent++;
      gap = $urandom_range(0, 17) * ($urandom_range(0, 3) == 0);
      if (gap == 0 && !hold_sender && pending_vecs.size() > 0) begin
        comp_x <= pending_vecs[0].x;
        comp_y <= pending_vecs[0].y;
        comp_z <= pending_vecs[0].z;
      end else begin
        gap_left <= gap;
        in_valid <= 1'b0;
      end
    end else if (!in_valid && rst_n && !hold_sender && pending_vecs.size() > 0) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else begin
        in_valid <= 1'b1;
        comp_x <= pending_vecs[0].x;
        comp_y <= pending_vecs[0].y;
        comp_z <= pending_vecs[0].z;
      end
    end
  end

  // monitor: checks each result transfer and draws receiver stalls
  always @(posedge clk) begin
    unit_t w;
    int wait_n;
    if (out_valid && out_ready) begin
      if (expected_units.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        w = expected_units.pop_front();
        if (unit_x !== w.ux) report_mismatch("unit_x", unit_x, w.ux);
        if (unit_y !== w.uy) report_mismatch("unit_y", unit_y, w.uy);
        if (unit_z !== w.uz) report_mismatch("unit_z", unit_z, w.uz);
        if (too_small !== w.small_f) report_mismatch("too_small", too_small, w.small_f);
        matched++;
        if (w.small_f) n_small++;
      end
      wait_n = $urandom_range(0, 17) * ($urandom_range(0, 3) == 0);
      stall_left <= wait_n;
      out_ready <= (wait_n == 0) && (stall_hold == 0);
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog expired");
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic signed [IW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return -(IW'(1) << (IW-1));
      1: return (IW'(1) << (IW-1)) - 1;
      2: return IW'($signed(IW'($urandom_range(0, 64))) - 32);
      3: return IW'($signed(IW'($urandom_range(0, 4096))) - 2048);
      default: return IW'($urandom);
    endcase
  endfunction

  task automatic write_min_norm(logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    min_norm_cfg = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (pending_vecs.size() > 0 || in_valid || expected_units.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    vec_t v;
    repeat (n) begin
      v.x = rand_comp(); v.y = rand_comp(); v.z = rand_comp();
      pending_vecs.push_back(v);
    end
  endtask

  localparam logic signed [IW-1:0] MAXP = (IW'(1) << (IW-1)) - 1;
  localparam logic signed [IW-1:0] MAXN = -(IW'(1) << (IW-1));

  initial begin
    logic [CFG_W-1:0] thresholds[5];
    int pause_at;
    thresholds = '{24'd0, 24'd1, 24'd3000, 24'hFFFFFF, 24'd20};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, zero vector, axes, small norm
    pending_vecs.push_back('{0, 0, 0});
    pending_vecs.push_back('{MAXP, 0, 0});
    pending_vecs.push_back('{MAXN, 0, 0});
    pending_vecs.push_back('{0, MAXN, 0});
    pending_vecs.push_back('{0, 0, MAXP});
    pending_vecs.push_back('{MAXN, MAXN, MAXN});
    pending_vecs.push_back('{MAXP, MAXP, MAXP});
    pending_vecs.push_back('{MAXP, MAXN, MAXP});
    pending_vecs.push_back('{1, 0, 0});
    pending_vecs.push_back('{-1, 0, 0});
    pending_vecs.push_back('{1, 1, 1});
    pending_vecs.push_back('{-1, -1, -1});
    pending_vecs.push_back('{3, 4, 0});
    pending_vecs.push_back('{-3, 0, 4});
    pending_vecs.push_back('{IW'(24'h555555), IW'(24'hAAAAAA), IW'(24'h0F0F0F)});
    pending_vecs.push_back('{IW'(24'hAAAAAA), IW'(24'h555555), IW'(24'hF0F0F0)});
    drain();
    // directed at a threshold: norm just at and just above
    write_min_norm(24'd5);
    pending_vecs.push_back('{3, 4, 0});
    pending_vecs.push_back('{0, 6, 0});
    pending_vecs.push_back('{0, 0, -5});
    pending_vecs.push_back('{0, 0, -6});
    drain();
    foreach (thresholds[i]) begin
      write_min_norm(thresholds[i]);
      queue_random(110);
      if (i == 1) begin
        // receiver holds off long so the pipeline fills and stalls its input
        stall_hold = 300;
      end
      drain();
    end
    // sender pauses mid-burst until every expected result has come
    pause_at = sent + 10;
    queue_random(30);
    while (sent < pause_at) @(posedge clk);
    hold_sender = 1'b1;
    while (in_valid || expected_units.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    hold_sender = 1'b0;
    drain();
    $display("covered %0d vectors over %0d thresholds, %0d forced to zero",
             sent, 6, n_small);
    if (errors == 0 && expected_units.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/vn_pkg.sv
rtl/vn_sqrt_pipe.sv
rtl/vn_div_pipe.sv
rtl/vector3_normalize_unit.sv
tb/tb_vector3_normalize_unit.sv
